[sv/smm_pkg.sv]
// Shared types and constants of the small matrix multiply unit.
package smm_pkg;

   localparam int DATA_W     = 32;
   localparam int IDX_W      = 2;
   localparam int ACT_W      = 2;
   localparam int CFG_W      = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;

   typedef enum logic [ACT_W-1:0] {
      ACT_LOAD_A  = 2'd0,
      ACT_LOAD_B  = 2'd1,
      ACT_COMPUTE = 2'd2
   } action_type;

   localparam logic [1:0] REG_ROWS_A    = 2'd0;
   localparam logic [1:0] REG_INNER_LEN = 2'd1;
   localparam logic [1:0] REG_COLS_B    = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_WAIT
   } seq_state_type;

   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } mac_ctrl_type;

endpackage

[sv/smm_if.sv]
// Valid/ready channel interfaces for request and response words.
interface smm_req_if import smm_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic [ACT_W-1:0]         action;
   logic [IDX_W-1:0]         row_index;
   logic [IDX_W-1:0]         col_index;
   logic signed [DATA_W-1:0] element;

   modport source (output valid, action, row_index, col_index, element, input ready);
   modport sink (input valid, action, row_index, col_index, element, output ready);
endinterface

interface smm_rsp_if import smm_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic [IDX_W-1:0]         out_row;
   logic [IDX_W-1:0]         out_col;
   logic signed [DATA_W-1:0] product_sum;
   logic                     last;

   modport source (output valid, out_row, out_col, product_sum, last, input ready);
   modport sink (input valid, out_row, out_col, product_sum, last, output ready);
endinterface

[sv/smm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module smm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/smm_csr.sv]
// Dimension registers behind the APB-style configuration port.
module smm_csr import smm_pkg::*; #(
   parameter int MAX_DIM = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [CSR_DATA_W-1:0]      csr_pwdata,
   output logic [CSR_DATA_W-1:0]      csr_prdata,
   output logic                       csr_pready,
   output logic [$clog2(MAX_DIM+1)-1:0] dim_rows,
   output logic [$clog2(MAX_DIM+1)-1:0] dim_inner,
   output logic [$clog2(MAX_DIM+1)-1:0] dim_cols
);

   localparam int DIM_W = $clog2(MAX_DIM + 1);

   logic [CFG_W-1:0] rows_a_ff, rows_a_in;
   logic [CFG_W-1:0] inner_len_ff, inner_len_in;
   logic [CFG_W-1:0] cols_b_ff, cols_b_in;
   logic             wr_en;
   logic [1:0]       reg_idx;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
      int t;
      t = int'(v);
      if (t < 1) begin
         t = 1;
      end else if (t > MAX_DIM) begin
         t = MAX_DIM;
      end
      return DIM_W'(t);
   endfunction

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[3:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      rows_a_in    = rows_a_ff;
      inner_len_in = inner_len_ff;
      cols_b_in    = cols_b_ff;
      csr_prdata   = '0;
      case (reg_idx)
         REG_ROWS_A: begin
            csr_prdata = CSR_DATA_W'(rows_a_ff);
            if (wr_en) begin
               rows_a_in = csr_pwdata[CFG_W-1:0];
            end
         end
         REG_INNER_LEN: begin
            csr_prdata = CSR_DATA_W'(inner_len_ff);
            if (wr_en) begin
               inner_len_in = csr_pwdata[CFG_W-1:0];
            end
         end
         REG_COLS_B: begin
            csr_prdata = CSR_DATA_W'(cols_b_ff);
            if (wr_en) begin
               cols_b_in = csr_pwdata[CFG_W-1:0];
            end
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff    <= CFG_W'(4);
         inner_len_ff <= CFG_W'(4);
         cols_b_ff    <= CFG_W'(4);
      end else begin
         rows_a_ff    <= rows_a_in;
         inner_len_ff <= inner_len_in;
         cols_b_ff    <= cols_b_in;
      end
   end

   assign dim_rows  = clamp_dim(rows_a_ff);
   assign dim_inner = clamp_dim(inner_len_ff);
   assign dim_cols  = clamp_dim(cols_b_ff);

endmodule

[sv/smm_mac.sv]
// Multiply-accumulate pipeline fed by the two matrix stores.
module smm_mac import smm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  mac_ctrl_type      issue,
   input  logic [DATA_W-1:0] a_data,
   input  logic [DATA_W-1:0] b_data,
   output logic              sum_valid,
   output logic [DATA_W-1:0] sum
);

   mac_ctrl_type      ctrl1_ff, ctrl2_ff;
   logic [DATA_W-1:0] prod_ff, prod_in;
   logic [DATA_W-1:0] acc_ff, acc_in;
   logic              sum_valid_ff, sum_valid_in;

   always_comb begin
      prod_in = a_data * b_data;
      acc_in  = acc_ff;
      if (ctrl2_ff.valid) begin
         acc_in = ctrl2_ff.first ? prod_ff : acc_ff + prod_ff;
      end
      sum_valid_in = sum_valid_ff;
      if (issue.valid && issue.first) begin
         sum_valid_in = 1'b0;
      end else if (ctrl2_ff.valid && ctrl2_ff.last) begin
         sum_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl1_ff     <= '0;
         ctrl2_ff     <= '0;
         sum_valid_ff <= 1'b0;
      end else begin
         ctrl1_ff     <= issue;
         ctrl2_ff     <= ctrl1_ff;
         sum_valid_ff <= sum_valid_in;
      end
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign sum_valid = sum_valid_ff;
   assign sum       = acc_ff;

endmodule

[sv/smm_seq.sv]
// Sequencer: store writes, element walk, read addressing and the response register.
module smm_seq import smm_pkg::*; #(
   parameter int MAX_DIM = 4
) (
   input  logic                                                clock,
   input  logic                                                reset,
   smm_req_if.sink                                             req_ch,
   smm_rsp_if.source                                           rsp_ch,
   input  logic [$clog2(MAX_DIM+1)-1:0]                        dim_rows,
   input  logic [$clog2(MAX_DIM+1)-1:0]                        dim_inner,
   input  logic [$clog2(MAX_DIM+1)-1:0]                        dim_cols,
   output logic                                                a_we,
   output logic                                                b_we,
   output logic [(MAX_DIM > 1 ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] wr_addr,
   output logic [(MAX_DIM > 1 ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] rd_addr_a,
   output logic [(MAX_DIM > 1 ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] rd_addr_b,
   output mac_ctrl_type                                        issue,
   input  logic                                                sum_valid,
   input  logic [DATA_W-1:0]                                   sum
);

   localparam int DIM_W  = $clog2(MAX_DIM + 1);
   localparam int CNT_W  = MAX_DIM > 1 ? $clog2(MAX_DIM) : 1;
   localparam int ADDR_W = MAX_DIM > 1 ? $clog2(MAX_DIM * MAX_DIM) : 1;

   seq_state_type     state_ff, state_in;
   logic [CNT_W-1:0]  i_ff, i_in;
   logic [CNT_W-1:0]  j_ff, j_in;
   logic [CNT_W-1:0]  k_ff, k_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]  rsp_row_ff, rsp_row_in;
   logic [IDX_W-1:0]  rsp_col_ff, rsp_col_in;
   logic [DATA_W-1:0] rsp_sum_ff, rsp_sum_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              accept;
   logic              load_ok;
   logic              i_last, j_last, k_last;
   logic              out_free;

   assign accept  = req_ch.valid & req_ch.ready;
   assign load_ok = (int'(req_ch.row_index) < MAX_DIM) && (int'(req_ch.col_index) < MAX_DIM);
   assign wr_addr = ADDR_W'(int'(req_ch.row_index) * MAX_DIM + int'(req_ch.col_index));
   assign a_we    = accept && (req_ch.action == ACT_LOAD_A) && load_ok;
   assign b_we    = accept && (req_ch.action == ACT_LOAD_B) && load_ok;

   assign rd_addr_a = ADDR_W'(int'(i_ff) * MAX_DIM + int'(k_ff));
   assign rd_addr_b = ADDR_W'(int'(k_ff) * MAX_DIM + int'(j_ff));

   assign i_last   = (DIM_W'(i_ff) + DIM_W'(1)) == dim_rows;
   assign j_last   = (DIM_W'(j_ff) + DIM_W'(1)) == dim_cols;
   assign k_last   = (DIM_W'(k_ff) + DIM_W'(1)) == dim_inner;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_sum_in   = rsp_sum_ff;
      rsp_last_in  = rsp_last_ff;
      req_ch.ready = 1'b0;
      issue.valid  = 1'b0;
      issue.first  = (k_ff == '0);
      issue.last   = k_last;
      case (state_ff)
         ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (accept && (req_ch.action == ACT_COMPUTE)) begin
               i_in     = '0;
               j_in     = '0;
               k_in     = '0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            issue.valid = 1'b1;
            if (k_last) begin
               state_in = ST_WAIT;
            end else begin
               k_in = k_ff + CNT_W'(1);
            end
         end
         ST_WAIT: begin
            if (sum_valid && out_free) begin
               rsp_valid_in = 1'b1;
               rsp_row_in   = IDX_W'(i_ff);
               rsp_col_in   = IDX_W'(j_ff);
               rsp_sum_in   = sum;
               rsp_last_in  = i_last && j_last;
               k_in         = '0;
               if (j_last) begin
                  j_in = '0;
                  i_in = i_ff + CNT_W'(1);
               end else begin
                  j_in = j_ff + CNT_W'(1);
               end
               state_in = (i_last && j_last) ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         i_ff         <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_row_ff  <= rsp_row_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_sum_ff  <= rsp_sum_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.out_row     = rsp_row_ff;
   assign rsp_ch.out_col     = rsp_col_ff;
   assign rsp_ch.product_sum = rsp_sum_ff;
   assign rsp_ch.last        = rsp_last_ff;

endmodule

[sv/small_matrix_multiply_unit.sv]
// Top level of the small signed integer matrix multiply unit.
// Load words write one 32-bit element of A or B into its store.
// A compute word walks C in row-major order; each element takes inner_len store reads,
// then the read, multiply and accumulate registers drain before the sum enters the
// response register. A run of rows_a * cols_b elements is followed by a new request
// word once the last element sits in the response register.
// The next element waits while the response register still holds an untaken word.
module small_matrix_multiply_unit import smm_pkg::*; #(
   parameter int MAX_DIM = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   smm_req_if.sink               req_ch,
   smm_rsp_if.source             rsp_ch,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int DIM_W  = $clog2(MAX_DIM + 1);
   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = MAX_DIM > 1 ? $clog2(DEPTH) : 1;

   logic [DIM_W-1:0]  dim_rows, dim_inner, dim_cols;
   logic              a_we, b_we;
   logic [ADDR_W-1:0] wr_addr, rd_addr_a, rd_addr_b;
   logic [DATA_W-1:0] a_data, b_data;
   mac_ctrl_type      issue;
   logic              sum_valid;
   logic [DATA_W-1:0] sum;

   smm_csr #(.MAX_DIM(MAX_DIM)) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .dim_rows    (dim_rows),
      .dim_inner   (dim_inner),
      .dim_cols    (dim_cols)
   );

   smm_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram_a (
      .clock   (clock),
      .wr_en   (a_we),
      .wr_addr (wr_addr),
      .wr_data (DATA_W'(req_ch.element)),
      .rd_addr (rd_addr_a),
      .rd_data (a_data)
   );

   smm_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram_b (
      .clock   (clock),
      .wr_en   (b_we),
      .wr_addr (wr_addr),
      .wr_data (DATA_W'(req_ch.element)),
      .rd_addr (rd_addr_b),
      .rd_data (b_data)
   );

   smm_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .issue     (issue),
      .a_data    (a_data),
      .b_data    (b_data),
      .sum_valid (sum_valid),
      .sum       (sum)
   );

   smm_seq #(.MAX_DIM(MAX_DIM)) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .dim_rows  (dim_rows),
      .dim_inner (dim_inner),
      .dim_cols  (dim_cols),
      .a_we      (a_we),
      .b_we      (b_we),
      .wr_addr   (wr_addr),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .issue     (issue),
      .sum_valid (sum_valid),
      .sum       (sum)
   );

endmodule
